/* src/ntct_pkg.sv */
// Shared types, constants and helpers for the normal triplet consistency tracker.
package ntct_pkg;

  localparam int COMP_BITS = 16;
  localparam int SCORE_BITS = 31;
  localparam int SUM_BITS = 34;
  localparam int IDX_OUT_BITS = 16;
  localparam int LANES = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int IN_DATA_BITS = 96;
  localparam int OUT_DATA_BITS = 88;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCURATE_COS_MIN = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEST_COS_MIN = 2'd1;

  localparam logic signed [SCORE_BITS-1:0] ACCURATE_COS_MIN_RESET = 31'sd267414059;
  localparam logic signed [SCORE_BITS-1:0] BEST_COS_MIN_RESET = 31'sd268271979;
  localparam logic signed [SCORE_BITS-1:0] DOT_LIMIT = 31'sd805306368;
  localparam logic signed [SUM_BITS-1:0] DOT_LIMIT_WIDE = 34'sd805306368;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] z;
    logic signed [COMP_BITS-1:0] y;
    logic signed [COMP_BITS-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t second;
    vec_t first;
  } pair_t;

  typedef struct packed {
    logic                    valid;
    logic                    restart;
    logic [IDX_OUT_BITS-1:0] idx;
  } meta_t;

  typedef struct packed {
    logic                         best_ok;
    logic signed [SCORE_BITS-1:0] best_score;
    logic [IDX_OUT_BITS-1:0]      best_index;
    logic                         window_accurate;
    logic                         score_valid;
    logic signed [SCORE_BITS-1:0] window_score;
  } result_t;

  function automatic logic signed [SCORE_BITS-1:0] sat_dot(input logic signed [SUM_BITS-1:0] s);
    logic signed [SCORE_BITS-1:0] r;
    if (s > DOT_LIMIT_WIDE) begin
      r = DOT_LIMIT;
    end else if (s < -DOT_LIMIT_WIDE) begin
      r = -DOT_LIMIT;
    end else begin
      r = s[SCORE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] smax(input logic signed [SCORE_BITS-1:0] a,
                                                        input logic signed [SCORE_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] smin(input logic signed [SCORE_BITS-1:0] a,
                                                        input logic signed [SCORE_BITS-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* src/ntct_lane.sv */
// One centre normal scored against the pair before and the pair after, three stages.
module ntct_lane (
  input  logic                                  clk,
  input  logic                                  en,
  input  ntct_pkg::vec_t                        centre,
  input  ntct_pkg::vec_t                        before0,
  input  ntct_pkg::vec_t                        before1,
  input  ntct_pkg::vec_t                        after0,
  input  ntct_pkg::vec_t                        after1,
  output logic signed [ntct_pkg::SCORE_BITS-1:0] score
);

  ntct_pkg::vec_t partner [4];
  logic signed [31:0] prod [4][3];
  logic signed [ntct_pkg::SCORE_BITS-1:0] dot [4];

  assign partner[0] = before0;
  assign partner[1] = before1;
  assign partner[2] = after0;
  assign partner[3] = after1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod[k][0] <= centre.x * partner[k].x;
        prod[k][1] <= centre.y * partner[k].y;
        prod[k][2] <= centre.z * partner[k].z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dot[k] <= ntct_pkg::sat_dot(ntct_pkg::SUM_BITS'(prod[k][0])
                                    + ntct_pkg::SUM_BITS'(prod[k][1])
                                    + ntct_pkg::SUM_BITS'(prod[k][2]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score <= ntct_pkg::smin(ntct_pkg::smax(dot[0], dot[1]), ntct_pkg::smax(dot[2], dot[3]));
    end
  end

endmodule

/* src/ntct_merge.sv */
// Merge of lane scores, threshold checks and best window tracker.
module ntct_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_en,
  input  ntct_pkg::meta_t                       meta,
  input  logic signed [ntct_pkg::SCORE_BITS-1:0] lane0_score,
  input  logic signed [ntct_pkg::SCORE_BITS-1:0] lane1_score,
  input  logic signed [ntct_pkg::SCORE_BITS-1:0] accurate_cos_min,
  input  logic signed [ntct_pkg::SCORE_BITS-1:0] best_cos_min,
  output ntct_pkg::result_t                     result
);

  logic                                   have_best;
  logic signed [ntct_pkg::SCORE_BITS-1:0]   best_cos;
  logic [ntct_pkg::IDX_OUT_BITS-1:0]        best_center;

  logic                                   have_best_next;
  logic signed [ntct_pkg::SCORE_BITS-1:0]   best_cos_next;
  logic [ntct_pkg::IDX_OUT_BITS-1:0]        best_center_next;
  logic                                   have_cur;
  logic                                   upd;
  logic                                   ok_next;
  logic signed [ntct_pkg::SCORE_BITS-1:0]   sc;

  always_comb begin
    sc = ntct_pkg::smax(lane0_score, lane1_score);
    have_cur = have_best && !meta.restart;
    upd = meta.valid && (!have_cur || (sc > best_cos));
    have_best_next = have_cur || upd;
    best_cos_next = upd ? sc : best_cos;
    best_center_next = upd ? meta.idx : best_center;
    ok_next = upd ? (sc >= best_cos_min) : (have_cur && (best_cos >= best_cos_min));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (item_en) begin
      have_best <= have_best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      best_cos <= best_cos_next;
      best_center <= best_center_next;
      result.window_score <= meta.valid ? sc : '0;
      result.score_valid <= meta.valid;
      result.window_accurate <= meta.valid && (sc >= accurate_cos_min);
      result.best_index <= have_best_next ? best_center_next : '0;
      result.best_score <= have_best_next ? best_cos_next : '0;
      result.best_ok <= have_best_next && ok_next;
    end
  end

endmodule

/* src/normal_triplet_consistency_tracker.sv */
// Top level of the normal triplet consistency tracker: window, lanes, merge and ports.
//
//   channel  direction  signals                              content
//   s_*      in         s_tvalid s_tready s_tdata s_tuser    one pair of normals per transaction
//   m_*      out        m_tvalid m_tready m_tdata            one result per input transaction
//   cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data  threshold register writes
//
// One transaction per cycle while the output is not stalled; products register on the
// accepting edge, then sum, lane compare and merge register in that order. The
// pipeline and output register form one stall domain: while a result waits on m_tready,
// the whole pipeline and s_tready hold.
// Reset clears the pair count, the best tracker and all stage valid bits, and returns
// both thresholds to their defaults. Configuration writes are taken in any cycle.
module normal_triplet_consistency_tracker #(
  parameter int INDEX_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [ntct_pkg::IN_DATA_BITS-1:0]        s_tdata,
  // restart
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // window_score, score_valid, window_accurate, best_index, best_score, best_ok, zero pad
  output logic [ntct_pkg::OUT_DATA_BITS-1:0]       m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ntct_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic signed [ntct_pkg::SCORE_BITS-1:0]   cfg_data
);

  localparam logic [INDEX_BITS-1:0] CountMax = {INDEX_BITS{1'b1}};

  logic signed [ntct_pkg::SCORE_BITS-1:0] accurate_cos_min;
  logic signed [ntct_pkg::SCORE_BITS-1:0] best_cos_min;

  logic [INDEX_BITS-1:0] pair_count;
  logic [INDEX_BITS-1:0] count_base;
  logic [INDEX_BITS-1:0] pair_count_next;
  logic [INDEX_BITS-1:0] centre_idx;
  logic [INDEX_BITS+ntct_pkg::IDX_OUT_BITS-1:0] centre_ext;

  ntct_pkg::pair_t held_before;
  ntct_pkg::pair_t held_centre;
  ntct_pkg::pair_t cur;
  ntct_pkg::vec_t  lane_centre [ntct_pkg::LANES];
  logic signed [ntct_pkg::SCORE_BITS-1:0] lane_score [ntct_pkg::LANES];

  ntct_pkg::meta_t meta_in;
  ntct_pkg::meta_t meta_q [3];
  logic [2:0]      stage_valid;
  logic            en;
  logic            accept;
  ntct_pkg::result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accurate_cos_min <= ntct_pkg::ACCURATE_COS_MIN_RESET;
      best_cos_min <= ntct_pkg::BEST_COS_MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ntct_pkg::REG_ACCURATE_COS_MIN: accurate_cos_min <= cfg_data;
        ntct_pkg::REG_BEST_COS_MIN:     best_cos_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept = s_tvalid && s_tready;
  assign cur = ntct_pkg::pair_t'(s_tdata);

  always_comb begin
    count_base = s_tuser ? '0 : pair_count;
    pair_count_next = (count_base != CountMax) ? count_base + INDEX_BITS'(1) : count_base;
    centre_idx = pair_count_next - INDEX_BITS'(2);
    centre_ext = {{ntct_pkg::IDX_OUT_BITS{1'b0}}, centre_idx};
    meta_in.valid = pair_count_next >= INDEX_BITS'(3);
    meta_in.restart = s_tuser;
    meta_in.idx = centre_ext[ntct_pkg::IDX_OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
    end else if (accept) begin
      pair_count <= pair_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_before <= s_tuser ? '0 : held_centre;
      held_centre <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      stage_valid <= {stage_valid[1:0], s_tvalid};
      m_tvalid <= stage_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[0] <= meta_in;
      meta_q[1] <= meta_q[0];
      meta_q[2] <= meta_q[1];
    end
  end

  assign lane_centre[0] = held_centre.first;
  assign lane_centre[1] = held_centre.second;

  for (genvar g = 0; g < ntct_pkg::LANES; g++) begin : g_lane
    ntct_lane u_lane (
      .clk     (clk),
      .en      (en),
      .centre  (lane_centre[g]),
      .before0 (held_before.first),
      .before1 (held_before.second),
      .after0  (cur.first),
      .after1  (cur.second),
      .score   (lane_score[g])
    );
  end

  ntct_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .item_en          (en && stage_valid[2]),
    .meta             (meta_q[2]),
    .lane0_score      (lane_score[0]),
    .lane1_score      (lane_score[1]),
    .accurate_cos_min (accurate_cos_min),
    .best_cos_min     (best_cos_min),
    .result           (result)
  );

  assign m_tdata = {{(ntct_pkg::OUT_DATA_BITS - $bits(ntct_pkg::result_t)){1'b0}}, result};

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_accurate_needs_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result.window_accurate && !result.score_valid))
    else $error("accurate window without valid score");

  a_score_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.window_score <= ntct_pkg::DOT_LIMIT
                  && result.window_score >= -ntct_pkg::DOT_LIMIT))
    else $error("window score out of range");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (pair_count == INDEX_BITS'(1)))
    else $error("restart did not reset pair count");

endmodule

/* test/tb_normal_triplet_consistency_tracker.sv */
// Testbench for the normal triplet consistency tracker: streamed pairs, scored against a local predictor.
`timescale 1ns / 1ps

module tb_normal_triplet_consistency_tracker;

  localparam int IDX_W = 16;
  localparam int COUNT_MAX = (1 << IDX_W) - 1;
  localparam int RES_BITS = $bits(ntct_pkg::result_t);
  localparam longint Q28_SAT = 805306368;
  localparam longint Q28_ONE = 268435456;
  localparam longint NO_BEST_YET = -64'sd2147483648;
  localparam logic [ntct_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ntct_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [ntct_pkg::IN_DATA_BITS-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [ntct_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [ntct_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic signed [ntct_pkg::SCORE_BITS-1:0] cfg_data;

  normal_triplet_consistency_tracker #(.INDEX_BITS(IDX_W)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  ntct_pkg::pair_t older_pair;
  ntct_pkg::pair_t centre_pair;
  int      seen_pairs;
  longint  top_score;
  logic [ntct_pkg::IDX_OUT_BITS-1:0] top_centre;
  longint  acc_min;
  longint  best_min;

  ntct_pkg::result_t predicted_results[$];

  bit src_idle_on;
  bit sink_stall_on;
  bit long_hold_req;
  int mismatches;
  int pairs_sent;
  int results_checked;
  int scored_windows;
  int accurate_windows;
  int best_ok_results;
  int settings_used;

  function automatic logic signed [ntct_pkg::COMP_BITS-1:0] clip16(input int v);
    logic [31:0] w;
    w = v;
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return w[15:0];
  endfunction

  function automatic int rnd_signed(input int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic ntct_pkg::vec_t random_vec(input int kind, input ntct_pkg::vec_t base,
                                                input int spread);
    ntct_pkg::vec_t v;
    logic [63:0] raw;
    int ext[5] = '{-32768, -16384, 0, 16384, 32767};
    case (kind)
      0: begin
        v.x = clip16(int'(base.x) + rnd_signed(spread));
        v.y = clip16(int'(base.y) + rnd_signed(spread));
        v.z = clip16(int'(base.z) + rnd_signed(spread));
      end
      1: begin
        v.x = clip16(rnd_signed(16384));
        v.y = clip16(rnd_signed(16384));
        v.z = clip16(rnd_signed(16384));
      end
      2: begin
        raw = {$urandom, $urandom};
        v = raw[47:0];
      end
      default: begin
        v.x = clip16(ext[$urandom_range(0, 4)]);
        v.y = clip16(ext[$urandom_range(0, 4)]);
        v.z = clip16(ext[$urandom_range(0, 4)]);
      end
    endcase
    return v;
  endfunction

  function automatic longint dot_q28(input ntct_pkg::vec_t a, input ntct_pkg::vec_t b);
    longint d;
    d = longint'(a.x) * longint'(b.x) + longint'(a.y) * longint'(b.y)
      + longint'(a.z) * longint'(b.z);
    if (d > Q28_SAT) d = Q28_SAT;
    if (d < -Q28_SAT) d = -Q28_SAT;
    return d;
  endfunction

  function automatic longint normal_support(input ntct_pkg::vec_t n, input ntct_pkg::pair_t pb,
                                            input ntct_pkg::pair_t pa);
    longint sb;
    longint sa;
    sb = dot_q28(n, pb.first);
    if (dot_q28(n, pb.second) > sb) sb = dot_q28(n, pb.second);
    sa = dot_q28(n, pa.first);
    if (dot_q28(n, pa.second) > sa) sa = dot_q28(n, pa.second);
    return (sa < sb) ? sa : sb;
  endfunction

  function automatic void clear_tracking();
    older_pair = '0;
    centre_pair = '0;
    seen_pairs = 0;
    top_centre = '0;
    top_score = NO_BEST_YET;
  endfunction

  function automatic ntct_pkg::result_t predict_tracker_result(input bit restart,
                                                               input ntct_pkg::pair_t cur);
    ntct_pkg::result_t r;
    longint score;
    longint alt;
    int centre_idx;
    r = '0;
    if (restart) clear_tracking();
    if (seen_pairs < COUNT_MAX) seen_pairs++;
    if (seen_pairs >= 3) begin
      score = normal_support(centre_pair.first, older_pair, cur);
      alt = normal_support(centre_pair.second, older_pair, cur);
      if (alt > score) score = alt;
      r.window_score = score[ntct_pkg::SCORE_BITS-1:0];
      r.score_valid = 1'b1;
      r.window_accurate = (score >= acc_min);
      if (score > top_score) begin
        top_score = score;
        centre_idx = seen_pairs - 2;
        top_centre = centre_idx[ntct_pkg::IDX_OUT_BITS-1:0];
      end
    end
    older_pair = centre_pair;
    centre_pair = cur;
    if (top_score != NO_BEST_YET) begin
      r.best_index = top_centre;
      r.best_score = top_score[ntct_pkg::SCORE_BITS-1:0];
      r.best_ok = (top_score >= best_min);
    end
    return r;
  endfunction

  task automatic send_pair(input bit restart, input ntct_pkg::pair_t p);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    s_tuser <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_results.insert(predicted_results.size(), predict_tracker_result(restart, p));
    pairs_sent++;
  endtask

  task automatic send_six(input bit restart, input int fx, input int fy, input int fz,
                          input int sx, input int sy, input int sz);
    ntct_pkg::pair_t p;
    p.first.x = clip16(fx);
    p.first.y = clip16(fy);
    p.first.z = clip16(fz);
    p.second.x = clip16(sx);
    p.second.y = clip16(sy);
    p.second.z = clip16(sz);
    send_pair(restart, p);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [ntct_pkg::CFG_INDEX_BITS-1:0] idx,
                          input logic signed [ntct_pkg::SCORE_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ntct_pkg::REG_ACCURATE_COS_MIN) begin
      acc_min = val;
    end else if (idx == ntct_pkg::REG_BEST_COS_MIN) begin
      best_min = val;
    end
  endtask

  task automatic set_thresholds(input int acc, input int best, input bit touch_spare);
    cfg_beat(ntct_pkg::REG_ACCURATE_COS_MIN, acc[ntct_pkg::SCORE_BITS-1:0]);
    cfg_beat(ntct_pkg::REG_BEST_COS_MIN, best[ntct_pkg::SCORE_BITS-1:0]);
    if (touch_spare) begin
      cfg_beat(REG_SPARE_A, ntct_pkg::SCORE_BITS'($urandom));
      cfg_beat(REG_SPARE_B, ntct_pkg::SCORE_BITS'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 3))
      0: return int'(Q28_ONE) - int'($urandom_range(0, 6000000));
      1: return int'($urandom_range(0, 1610612736)) - int'(Q28_SAT);
      2: return ($urandom_range(0, 1) != 0) ? int'(Q28_SAT) : -int'(Q28_SAT);
      default: return int'(Q28_ONE) - int'($urandom_range(0, 300000));
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    ntct_pkg::result_t got;
    ntct_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = ntct_pkg::result_t'(m_tdata[RES_BITS-1:0]);
      if (predicted_results.size() == 0) begin
        mismatches++;
        $error("result transaction with no pending prediction");
      end else begin
        want = predicted_results.pop_front();
        check_field("window_score", want.window_score, got.window_score);
        check_field("score_valid", want.score_valid, got.score_valid);
        check_field("window_accurate", want.window_accurate, got.window_accurate);
        check_field("best_index", want.best_index, got.best_index);
        check_field("best_score", want.best_score, got.best_score);
        check_field("best_ok", want.best_ok, got.best_ok);
        check_field("pad", 0, m_tdata[ntct_pkg::OUT_DATA_BITS-1:RES_BITS]);
        results_checked++;
        if (want.score_valid) scored_windows++;
        if (want.window_accurate) accurate_windows++;
        if (want.best_ok) best_ok_results++;
      end
    end
  end

  initial begin : result_sink
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_directed_pairs();
    src_idle_on = 1'b1;
    sink_stall_on = 1'b1;
    send_six(1, 0, 0, 0, 0, 0, 0);
    send_six(0, 16384, 0, 0, 0, 16384, 0);
    send_six(0, 16384, 0, 0, 0, 0, 16384);
    send_six(0, -16384, -16384, -16384, 16384, 16384, 16384);
    send_six(0, 32767, 32767, 32767, 32767, 32767, 32767);
    send_six(0, -32768, -32768, -32768, 32767, 32767, 32767);
    send_six(0, 32767, 32767, 32767, -32768, -32768, -32768);
    send_six(0, 21845, 21845, 21845, -21846, -21846, -21846);
    send_six(0, -21846, -21846, -21846, 21845, 21845, 21845);
    send_six(0, 16384, 0, 0, 16384, 0, 0);
    send_six(0, 16384, 0, 0, 16384, 0, 0);
    send_six(0, 16384, 0, 0, 16384, 0, 0);
    send_six(1, 0, 16384, 0, 0, 16384, 0);
    send_six(1, 0, 16384, 0, 0, 16384, 0);
    send_six(0, 0, 16384, 0, 0, 16384, 0);
    send_six(0, 0, 16384, 0, 0, 16384, 0);
    send_six(0, 0, -16384, 0, 0, -16384, 0);
    send_six(0, 16383, -1, 1, -16384, 16384, -16384);
    send_six(0, 0, 0, -16384, 0, 0, 16384);
    send_six(0, -1, -1, -1, 1, 1, 1);
    send_six(0, 11585, 11585, 0, 0, 11585, 11585);
    send_six(0, 11585, 0, 11585, 11585, 11585, 0);
    wait_all_results();
  endtask

  task automatic test_threshold_extremes();
    int accs[4];
    int bests[4];
    int k;
    accs = '{int'(Q28_SAT), -int'(Q28_SAT), int'(Q28_ONE),
             int'(ntct_pkg::ACCURATE_COS_MIN_RESET)};
    bests = '{-int'(Q28_SAT), int'(Q28_SAT), int'(Q28_ONE) + 1,
              int'(ntct_pkg::BEST_COS_MIN_RESET)};
    for (k = 0; k < 4; k++) begin
      set_thresholds(accs[k], bests[k], k == 2);
      send_six(1, 16384, 0, 0, 16384, 0, 0);
      send_six(0, 16384, 0, 0, 16384, 0, 0);
      send_six(0, 16384, 0, 0, 16384, 0, 0);
      send_six(0, -16384, 0, 0, -16384, 0, 0);
      send_six(1, 32767, 32767, 32767, 32767, 32767, 32767);
      send_six(0, 32767, 32767, 32767, 32767, 32767, 32767);
      send_six(0, 32767, 32767, 32767, 32767, 32767, 32767);
      wait_all_results();
    end
  endtask

  task automatic test_output_backpressure();
    ntct_pkg::pair_t p;
    ntct_pkg::vec_t zero_vec;
    int k;
    zero_vec = '0;
    src_idle_on = 1'b0;
    sink_stall_on = 1'b0;
    long_hold_req = 1'b1;
    for (k = 0; k < 48; k++) begin
      p.first = random_vec(1, zero_vec, 0);
      p.second = random_vec(1, zero_vec, 0);
      send_pair(k == 0 || $urandom_range(0, 15) == 0, p);
    end
    wait_all_results();
  endtask

  task automatic test_random_sequences(input int n_items, input bit idle_allowed);
    int spreads[4] = '{0, 40, 400, 3000};
    int sent;
    int seq_len;
    int spread;
    int k;
    bit restart;
    ntct_pkg::vec_t base;
    ntct_pkg::vec_t zero_vec;
    ntct_pkg::pair_t p;
    zero_vec = '0;
    sent = 0;
    while (sent < n_items) begin
      seq_len = $urandom_range(3, 40);
      spread = spreads[$urandom_range(0, 3)];
      if ($urandom_range(0, 1) != 0) begin
        base = '0;
        case ($urandom_range(0, 2))
          0: base.x = clip16(($urandom_range(0, 1) != 0) ? 16384 : -16384);
          1: base.y = clip16(($urandom_range(0, 1) != 0) ? 16384 : -16384);
          default: base.z = clip16(($urandom_range(0, 1) != 0) ? 16384 : -16384);
        endcase
      end else begin
        base = random_vec(1, zero_vec, 0);
      end
      src_idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
      sink_stall_on = idle_allowed && ($urandom_range(0, 2) != 0);
      for (k = 0; k < seq_len && sent < n_items; k++) begin
        restart = (k == 0) ? ($urandom_range(0, 1) != 0) : ($urandom_range(0, 59) == 0);
        if ($urandom_range(0, 9) < 8) begin
          p.first = random_vec(0, base, spread);
        end else begin
          p.first = random_vec($urandom_range(1, 3), base, 0);
        end
        p.second = random_vec($urandom_range(0, 3), base, spread * 4);
        send_pair(restart, p);
        sent++;
        if ($urandom_range(0, 7) == 0) base = random_vec(0, base, 300);
      end
    end
    wait_all_results();
  endtask

  initial begin : stimulus
    int phase;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    acc_min = ntct_pkg::ACCURATE_COS_MIN_RESET;
    best_min = ntct_pkg::BEST_COS_MIN_RESET;
    clear_tracking();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_pairs();
    test_threshold_extremes();
    test_output_backpressure();
    for (phase = 0; phase < 4; phase++) begin
      set_thresholds(pick_threshold(), pick_threshold(), phase == 0);
      test_random_sequences(350, 1'b1);
    end
    set_thresholds(pick_threshold(), pick_threshold(), 1'b0);
    test_random_sequences(250, 1'b0);
    repeat (12) @(posedge clk);
    $display("Covered %0d pairs under %0d threshold settings, %0d results compared",
             pairs_sent, settings_used, results_checked);
    $display("Scored windows %0d, accurate %0d, best within limit %0d",
             scored_windows, accurate_windows, best_ok_results);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
